[design/assert_macros.svh]
// Assertion macros shared by the enumerator RTL.
// Each use expects clk and rst_n in scope of the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("enumerator assertion failed");

// Invariant checked at every rising edge outside reset.
`define CWE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("enumerator invariant failed");

`endif

[design/cwe_pkg.sv]
// Shared types, register codes and symbol table of the word enumerator.
// No dependencies; used by every other file of the block but the assertion macros.
`default_nettype none

package cwe_pkg;

  localparam int CWE_MAX_WORD_LEN = 8;
  localparam int CWE_WORD_W       = 64;
  localparam int CWE_LEN_W        = 4;
  localparam int CWE_DIGIT_W      = 7;
  localparam int CWE_CFG_IDX_W    = 3;
  localparam int CWE_Q_DEPTH      = 2;
  localparam int CWE_Q_PTR_W      = (CWE_Q_DEPTH > 1) ? $clog2(CWE_Q_DEPTH) : 1;
  localparam int CWE_Q_CNT_W      = $clog2(CWE_Q_DEPTH + 1);

  localparam int SYM_COUNT = 86;
  localparam logic [SYM_COUNT*8-1:0] SYM_STR = {
    "abcdefghijklmnopqrstuvwxyz",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
    "0123456789",
    "!@#$%^&*()_+{}[]|;:,.<>?"
  };

  typedef enum logic [CWE_CFG_IDX_W-1:0] {
    REG_CHARSET_LEVEL  = 3'd0,
    REG_SHORT_LEN      = 3'd1,
    REG_LONG_LEN       = 3'd2,
    REG_PATTERN_BYTES  = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cwe_reg_t;

  typedef struct packed {
    logic [1:0]            charset_level;
    logic [CWE_LEN_W-1:0]  short_len;
    logic [CWE_LEN_W-1:0]  long_len;
    logic [CWE_WORD_W-1:0] pattern_bytes;
    logic [CWE_LEN_W-1:0]  pattern_length;
  } cwe_cfg_t;

  // Per-word status carried through the queue beside the digits
  typedef struct packed {
    logic [CWE_LEN_W-1:0] len;
    logic                 done;
  } cwe_tag_t;

  localparam int CWE_TAG_W = $bits(cwe_tag_t);

  function automatic logic [7:0] cwe_radix(input logic [1:0] level);
    logic [7:0] r;
    case (level)
      2'd0:    r = 8'd26;
      2'd1:    r = 8'd52;
      2'd2:    r = 8'd62;
      default: r = 8'd86;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cwe_sym_char(input logic [CWE_DIGIT_W-1:0] idx);
    logic [9:0] off;
    off = 10'(((SYM_COUNT - 1) - int'(idx)) * 8);
    if (int'(idx) >= SYM_COUNT) begin
      return 8'h00;
    end
    return SYM_STR[off +: 8];
  endfunction

endpackage

`default_nettype wire

[design/cwe_if.sv]
// Valid/ready channel interfaces of the word enumerator.
// Depends on cwe_pkg for field widths.
`default_nettype none

interface cwe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cwe_out_if;
  logic                           valid;
  logic                           ready;
  logic [cwe_pkg::CWE_WORD_W-1:0] word;
  logic [cwe_pkg::CWE_LEN_W-1:0]  word_length;
  logic                           matched;
  logic                           exhausted;

  modport source (output valid, output word, output word_length, output matched,
                  output exhausted, input ready);
  modport sink   (input valid, input word, input word_length, input matched,
                  input exhausted, output ready);
endinterface

`default_nettype wire

[design/cwe_front.sv]
// Front end: accepts beats, holds the odometer and classifies each word.
// Depends on cwe_pkg and cwe_if; feeds cwe_queue.
`default_nettype none
`include "assert_macros.svh"

module cwe_front #(
  parameter int MAX_WORD_LEN = cwe_pkg::CWE_MAX_WORD_LEN
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  cwe_in_if.sink                                            in_if,
  input  wire cwe_pkg::cwe_cfg_t                            cfg,
  input  wire logic                                         q_full,
  output logic                                              push,
  output logic [MAX_WORD_LEN-1:0][cwe_pkg::CWE_DIGIT_W-1:0] push_digits,
  output cwe_pkg::cwe_tag_t                                 push_tag
);
  import cwe_pkg::*;

  localparam logic [CWE_LEN_W-1:0] LEN_MAX = CWE_LEN_W'(MAX_WORD_LEN);

  logic [MAX_WORD_LEN-1:0][CWE_DIGIT_W-1:0] digits_r, digits_nxt;
  logic [CWE_LEN_W-1:0]                     len_r, len_nxt;
  logic                                     done_r, done_nxt;

  logic [CWE_LEN_W-1:0]                     eff_min, eff_max;
  logic [MAX_WORD_LEN-1:0][CWE_DIGIT_W-1:0] cur_dig, adv_dig;
  logic [CWE_LEN_W-1:0]                     cur_len;
  logic                                     cur_done, chk_done, wrap;
  logic [7:0]                               radix;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    logic       c;
    logic [7:0] inc;
    eff_min = (cfg.short_len == '0) ? CWE_LEN_W'(1) : cfg.short_len;
    eff_max = (cfg.long_len > LEN_MAX) ? LEN_MAX : cfg.long_len;
    radix   = cwe_radix(cfg.charset_level);

    if (in_if.restart) begin
      cur_dig  = '0;
      cur_len  = eff_min;
      cur_done = eff_min > eff_max;
    end else begin
      cur_dig  = digits_r;
      cur_len  = len_r;
      cur_done = done_r;
    end
    // a held length outside the bounds ends the run
    chk_done = cur_done || (cur_len < eff_min) || (cur_len > eff_max) || (cur_len == '0);

    // ripple the increment from the last active position towards the first
    c = 1'b1;
    for (int i = MAX_WORD_LEN - 1; i >= 0; i--) begin
      adv_dig[i] = cur_dig[i];
      inc        = {1'b0, cur_dig[i]} + 8'd1;
      if ((CWE_LEN_W'(i) < cur_len) && c) begin
        if (inc >= radix) begin
          adv_dig[i] = '0;
        end else begin
          adv_dig[i] = inc[CWE_DIGIT_W-1:0];
          c          = 1'b0;
        end
      end
    end
    wrap = c;

    digits_nxt = digits_r;
    len_nxt    = len_r;
    done_nxt   = done_r;
    if (push) begin
      if (chk_done) begin
        digits_nxt = cur_dig;
        len_nxt    = cur_len;
        done_nxt   = 1'b1;
      end else if (wrap) begin
        digits_nxt = '0;
        len_nxt    = cur_len + CWE_LEN_W'(1);
        done_nxt   = (cur_len + CWE_LEN_W'(1)) > eff_max;
      end else begin
        digits_nxt = adv_dig;
        len_nxt    = cur_len;
        done_nxt   = 1'b0;
      end
    end
  end

  assign push_digits   = cur_dig;
  assign push_tag.len  = cur_len;
  assign push_tag.done = chk_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
      len_r    <= CWE_LEN_W'(1);
      done_r   <= 1'b0;
    end else begin
      digits_r <= digits_nxt;
      len_r    <= len_nxt;
      done_r   <= done_nxt;
    end
  end

  `CWE_ASSERT_IMP(a_live_len_in_range, push && !push_tag.done,
                  push_tag.len >= CWE_LEN_W'(1) && push_tag.len <= LEN_MAX)
  `CWE_ASSERT_IMP(a_done_sticks, !push && done_r, ##1 done_r)

endmodule

`default_nettype wire

[design/cwe_queue.sv]
// Short queue between front and back end of the enumerator.
// Depends on cwe_pkg for its depth.
`default_nettype none
`include "assert_macros.svh"

module cwe_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output logic [DW-1:0]      head
);
  import cwe_pkg::*;

  localparam logic [CWE_Q_CNT_W-1:0] DEPTH_C = CWE_Q_CNT_W'(CWE_Q_DEPTH);
  localparam logic [CWE_Q_PTR_W-1:0] LAST_P  = CWE_Q_PTR_W'(CWE_Q_DEPTH - 1);

  logic [DW-1:0]          mem_r [CWE_Q_DEPTH];
  logic [CWE_Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CWE_Q_CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == DEPTH_C;
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CWE_Q_CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CWE_Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + CWE_Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + CWE_Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  `CWE_ASSERT_ALWAYS(a_count_bounded, count_r <= DEPTH_C)
  `CWE_ASSERT_IMP(a_no_overflow, push && !pop, count_r != DEPTH_C)
  `CWE_ASSERT_IMP(a_no_underflow, pop, count_r != '0)

endmodule

`default_nettype wire

[design/cwe_back.sv]
// Back end: turns queued digits into characters, matches the pattern and
// holds the result register. Depends on cwe_pkg and cwe_if.
`default_nettype none
`include "assert_macros.svh"

module cwe_back #(
  parameter int MAX_WORD_LEN = cwe_pkg::CWE_MAX_WORD_LEN
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire cwe_pkg::cwe_cfg_t                            cfg,
  input  wire logic                                         q_valid,
  input  wire logic [MAX_WORD_LEN-1:0][cwe_pkg::CWE_DIGIT_W-1:0] q_digits,
  input  wire cwe_pkg::cwe_tag_t                            q_tag,
  output logic                                              pop,
  cwe_out_if.source                                         out_if
);
  import cwe_pkg::*;

  logic                  out_valid_r;
  logic [CWE_WORD_W-1:0] word_r, word_nxt;
  logic [CWE_LEN_W-1:0]  wlen_r, wlen_nxt;
  logic                  match_r, match_nxt;
  logic                  exh_r, exh_nxt;

  logic [7:0]            chars [MAX_WORD_LEN];
  logic [CWE_LEN_W-1:0]  plen;
  logic [7:0]            radix;

  assign pop = q_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    logic [7:0] d;
    logic       win_ok;
    logic       any;
    radix = cwe_radix(cfg.charset_level);
    plen  = (cfg.pattern_length > CWE_LEN_W'(8)) ? CWE_LEN_W'(8) : cfg.pattern_length;

    // a digit beyond the current charset shows as its last symbol
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      d = {1'b0, q_digits[i]};
      if (d >= radix) begin
        d = radix - 8'd1;
      end
      chars[i] = cwe_sym_char(d[CWE_DIGIT_W-1:0]);
    end

    word_nxt = '0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (CWE_LEN_W'(i) < q_tag.len) begin
        word_nxt[8*i +: 8] = chars[i];
      end
    end

    any = 1'b0;
    for (int s = 0; s < MAX_WORD_LEN; s++) begin
      win_ok = (5'(s) + {1'b0, plen}) <= {1'b0, q_tag.len};
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
        if (CWE_LEN_W'(i) < plen) begin
          if (s + i >= MAX_WORD_LEN) begin
            win_ok = 1'b0;
          end else if (chars[(s + i) % MAX_WORD_LEN] != cfg.pattern_bytes[8*i +: 8]) begin
            win_ok = 1'b0;
          end
        end
      end
      any = any | win_ok;
    end

    if (q_tag.done) begin
      word_nxt  = '0;
      wlen_nxt  = '0;
      match_nxt = 1'b0;
      exh_nxt   = 1'b1;
    end else begin
      wlen_nxt  = q_tag.len;
      match_nxt = (plen == '0) || any;
      exh_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r  <= word_nxt;
      wlen_r  <= wlen_nxt;
      match_r <= match_nxt;
      exh_r   <= exh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.word        = word_r;
  assign out_if.word_length = wlen_r;
  assign out_if.matched     = match_r;
  assign out_if.exhausted   = exh_r;

  `CWE_ASSERT_IMP(a_exhausted_blank, out_valid_r && exh_r,
                  word_r == '0 && wlen_r == '0 && !match_r)
  `CWE_ASSERT_IMP(a_live_has_length, out_valid_r && !exh_r, wlen_r != '0)

endmodule

`default_nettype wire

[design/charset_word_enumerator_with_filter_core.sv]
// Top level of the charset word enumerator: configuration registers,
// front end, queue and back end. Depends on cwe_pkg, cwe_if and all cwe_ modules.
`default_nettype none

// Each input beat with restart high reloads the first word of the selected
// charset and length range; with restart low it takes the next word of the
// odometer. One result beat follows every input beat: the word, its length,
// whether it holds the pattern, or an exhausted marker once the list is
// through. One beat is taken per clock cycle while the queue is not full, as
// the carry ripples combinationally across the odometer positions; a result
// passes from the front end into a two-entry queue, then into the result
// register, and the queue lets input continue while a result waits.
// Configuration writes land at once and are meant for an idle block; there
// is no clearing pass after reset.
module charset_word_enumerator_with_filter_core #(
  parameter int MAX_WORD_LEN = cwe_pkg::CWE_MAX_WORD_LEN
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  cwe_in_if.sink                                    in_if,
  cwe_out_if.source                                 out_if,
  input  wire logic                                 cfg_we,
  input  wire logic [cwe_pkg::CWE_CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cwe_pkg::CWE_WORD_W-1:0]       cfg_wdata
);
  import cwe_pkg::*;

  localparam int QDW = MAX_WORD_LEN * CWE_DIGIT_W + CWE_TAG_W;

  cwe_cfg_t cfg_r;

  logic                                     push, pop, q_full, q_valid;
  logic [MAX_WORD_LEN-1:0][CWE_DIGIT_W-1:0] push_digits, q_digits;
  cwe_tag_t                                 push_tag, q_tag;
  logic [QDW-1:0]                           q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charset_level  <= 2'd0;
      cfg_r.short_len      <= CWE_LEN_W'(1);
      cfg_r.long_len       <= CWE_LEN_W'(8);
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHARSET_LEVEL:  cfg_r.charset_level  <= cfg_wdata[1:0];
        REG_SHORT_LEN:      cfg_r.short_len      <= cfg_wdata[CWE_LEN_W-1:0];
        REG_LONG_LEN:       cfg_r.long_len       <= cfg_wdata[CWE_LEN_W-1:0];
        REG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= cfg_wdata;
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[CWE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  cwe_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .push        (push),
    .push_digits (push_digits),
    .push_tag    (push_tag)
  );

  cwe_queue #(.DW(QDW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_tag, push_digits}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign q_digits = q_head[MAX_WORD_LEN*CWE_DIGIT_W-1:0];
  assign q_tag    = q_head[QDW-1 -: CWE_TAG_W];

  cwe_back #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_digits (q_digits),
    .q_tag    (q_tag),
    .pop      (pop),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire
